// ----- rtl/core/set_pkg.sv -----
// Shared types and constants for the Sobel edge threshold block.
// No dependencies; compiled first.
package set_pkg;

  localparam int PIXEL_W      = 8;
  localparam int COLUMN_W     = 12;
  localparam int ROW_W        = 16;
  localparam int IMG_WIDTH_W  = 13;
  localparam int IMG_HEIGHT_W = 16;
  localparam int THRESH_W     = 23;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 23;

  typedef logic [PIXEL_W-1:0]    pixel_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_THRESHOLD_SQ = 2'd2;

  localparam logic [IMG_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd480;
  localparam logic [THRESH_W-1:0]     THRESHOLD_RST    = 23'd10000;

  // One column of the two stored rows: upper is two rows up, middle one row up.
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } lines_t;

endpackage

// ----- rtl/core/set_pixel_if.sv -----
// Pixel input channel: valid/ready handshake with one grey pixel.
// Depends on set_pkg.
interface set_pixel_if;
  import set_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ----- rtl/core/set_result_if.sv -----
// Result channel: valid/ready handshake with one edge decision and its position.
// Depends on set_pkg.
interface set_result_if;
  import set_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLUMN_W-1:0] column;
  logic [ROW_W-1:0]    row;
  logic                is_edge;
  logic                last_of_item;
  logic                last_of_frame;

  modport source (output valid, output column, output row, output is_edge,
                  output last_of_item, output last_of_frame, input ready);
  modport sink   (input valid, input column, input row, input is_edge,
                  input last_of_item, input last_of_frame, output ready);
endinterface

// ----- rtl/core/set_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on set_pkg.
interface set_cfg_if;
  import set_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/set_line_store.sv -----
// Two line stores (upper and middle rows) with registered read and write bypass.
// Depends on set_pkg.
module set_line_store #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  set_pkg::lines_t          wr_data,
  output set_pkg::lines_t          rd_data
);
  import set_pkg::*;

  pixel_t mem_upper [DEPTH];
  pixel_t mem_middle [DEPTH];
  lines_t q_r;
  lines_t byp_data_r;
  logic   byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr]  <= wr_data.upper;
      mem_middle[wr_addr] <= wr_data.middle;
    end
    if (rd_en) begin
      q_r.upper  <= mem_upper[rd_addr];
      q_r.middle <= mem_middle[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // read and write to one address at the same edge: take the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : q_r;

endmodule

// ----- rtl/core/sobel_edge_threshold.sv -----
// Sobel edge threshold: raster pixels in, one edge/non-edge result per pixel out.
// Depends on set_pkg, set_pixel_if, set_result_if, set_cfg_if, set_line_store.
//
// Accepts one 8-bit pixel per clock in raster order while the output keeps up,
// and marks every pixel of the frame as edge or non-edge, using gx^2+gy^2 >=
// threshold_squared over a 3x3 window with weights 1,CENTRE_WEIGHT,1. Border pixels
// are reported as non-edge in the transaction after they arrive; interior pixel
// (x-1,y-1) is reported on arrival of pixel (x,y), before any border result of that
// pixel. Pixels pass three registers (line store read, gradient, result) before
// their result leaves. The rate is one pixel per clock while the output keeps up,
// with one line store read and one line store write per cycle; a pixel at column
// two or more and row two or more that lies in the last column or the last row
// yields two results, the result register then holds until both are taken, and
// once the pipeline is full the input stalls meanwhile. Configuration writes are
// taken in every cycle and must only be issued while the block is idle.
module sobel_edge_threshold #(
  parameter int MAX_WIDTH     = 4096,
  parameter int CENTRE_WEIGHT = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  set_pixel_if.sink     in_px,
  set_result_if.source  out_res,
  set_cfg_if.sink       cfg_wr
);
  import set_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (XW + 1 > IMG_WIDTH_W) ? XW + 1 : IMG_WIDTH_W;
  localparam int GW   = $clog2((CENTRE_WEIGHT + 2) * 255 + 1) + 1;
  localparam int SQW  = 2 * GW + 1;
  localparam int TW   = (SQW > THRESH_W) ? SQW : THRESH_W;

  // configuration
  logic [IMG_WIDTH_W-1:0]  width_r;
  logic [IMG_HEIGHT_W-1:0] height_r;
  logic [THRESH_W-1:0]     thresh_r;

  // position counters
  logic [XW-1:0]    col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;

  // stage A: pixel and line store read
  logic             a_v_r;
  pixel_t           a_pix_r;
  logic [XW-1:0]    a_col_r;
  logic [ROW_W-1:0] a_row_r;
  logic             a_border_r, a_interior_r, a_fend_r;

  // stage B: gradients
  logic                 b_v_r;
  logic signed [GW-1:0] b_gx_r, b_gy_r;
  logic [XW-1:0]        b_col_r;
  logic [ROW_W-1:0]     b_row_r;
  logic                 b_border_r, b_interior_r, b_fend_r;

  // result register: interior and border results pending
  logic             o_int_r, o_bord_r;
  logic [XW-1:0]    o_col_r;
  logic [ROW_W-1:0] o_row_r;
  logic             o_edge_r, o_fend_r;

  pixel_t win_r   [9];
  pixel_t win_nxt [9];

  logic in_acc, out_acc, a_move, b_move;
  logic a_ready, b_ready, o_ready;

  logic [CMPW-1:0]         w_raw, w_max, w_eff, x_next1;
  logic [IMG_HEIGHT_W-1:0] h_eff;
  logic [ROW_W:0]          y_next1;
  logic                    row_end, last_row, frame_end, border, interior;

  lines_t lines, wr_lines;

  logic signed [GW-1:0]     gx_nxt, gy_nxt;
  logic signed [2*GW-1:0]   sqx, sqy;
  logic [TW-1:0]            mag;
  logic                     edge_nxt;

  function automatic logic signed [GW-1:0] ext(input pixel_t p);
    return $signed({{(GW - PIXEL_W){1'b0}}, p});
  endfunction

  // handshakes
  assign out_acc = out_res.valid && out_res.ready;
  assign o_ready = !(o_int_r || o_bord_r) || (out_res.ready && (o_int_r ^ o_bord_r));
  assign b_ready = !b_v_r || o_ready;
  assign a_ready = !a_v_r || b_ready;
  assign in_px.ready = a_ready;
  assign in_acc = in_px.valid && a_ready;
  assign a_move = a_v_r && b_ready;
  assign b_move = b_v_r && o_ready;
  assign cfg_wr.ready = 1'b1;

  // frame position
  always_comb begin
    w_raw = CMPW'(width_r);
    w_max = CMPW'(MAX_WIDTH);
    if (w_raw == '0) begin
      w_eff = CMPW'(1);
    end else if (w_raw > w_max) begin
      w_eff = w_max;
    end else begin
      w_eff = w_raw;
    end
    h_eff     = (height_r == '0) ? IMG_HEIGHT_W'(1) : height_r;
    x_next1   = CMPW'(col_cnt_r) + CMPW'(1);
    y_next1   = {1'b0, row_cnt_r} + (ROW_W + 1)'(1);
    row_end   = x_next1 >= w_eff;
    last_row  = y_next1 >= (ROW_W + 1)'(h_eff);
    frame_end = row_end && last_row;
    border    = (col_cnt_r == '0) || row_end || (row_cnt_r == '0) || last_row;
    interior  = (col_cnt_r >= XW'(2)) && (row_cnt_r >= ROW_W'(2));
  end

  assign wr_lines.upper  = lines.middle;
  assign wr_lines.middle = a_pix_r;

  set_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (col_cnt_r),
    .wr_en   (a_move),
    .wr_addr (a_col_r),
    .wr_data (wr_lines),
    .rd_data (lines)
  );

  // window shift and gradients
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3 + 0] = win_r[r*3 + 1];
      win_nxt[r*3 + 1] = win_r[r*3 + 2];
    end
    win_nxt[2] = lines.upper;
    win_nxt[5] = lines.middle;
    win_nxt[8] = a_pix_r;
    gx_nxt = (ext(win_nxt[6]) + GW'(CENTRE_WEIGHT) * ext(win_nxt[7]) + ext(win_nxt[8]))
           - (ext(win_nxt[0]) + GW'(CENTRE_WEIGHT) * ext(win_nxt[1]) + ext(win_nxt[2]));
    gy_nxt = (ext(win_nxt[2]) + GW'(CENTRE_WEIGHT) * ext(win_nxt[5]) + ext(win_nxt[8]))
           - (ext(win_nxt[0]) + GW'(CENTRE_WEIGHT) * ext(win_nxt[3]) + ext(win_nxt[6]));
  end

  // magnitude compare
  assign sqx      = b_gx_r * b_gx_r;
  assign sqy      = b_gy_r * b_gy_r;
  assign mag      = TW'($unsigned(sqx)) + TW'($unsigned(sqy));
  assign edge_nxt = mag >= TW'(thresh_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= IMAGE_WIDTH_RST;
      height_r  <= IMAGE_HEIGHT_RST;
      thresh_r  <= THRESHOLD_RST;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      a_v_r     <= 1'b0;
      b_v_r     <= 1'b0;
      o_int_r   <= 1'b0;
      o_bord_r  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_wr.data[IMG_WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_r <= cfg_wr.data[IMG_HEIGHT_W-1:0];
          REG_THRESHOLD_SQ: thresh_r <= cfg_wr.data[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (row_end) begin
          col_cnt_r <= '0;
          row_cnt_r <= frame_end ? '0 : y_next1[ROW_W-1:0];
        end else begin
          col_cnt_r <= col_cnt_r + XW'(1);
        end
      end
      if (in_acc) begin
        a_v_r <= 1'b1;
      end else if (a_move) begin
        a_v_r <= 1'b0;
      end
      if (a_move) begin
        b_v_r <= 1'b1;
        win_r <= win_nxt;
      end else if (b_move) begin
        b_v_r <= 1'b0;
      end
      if (b_move) begin
        o_int_r  <= b_interior_r;
        o_bord_r <= b_border_r;
      end else if (out_acc) begin
        if (o_int_r) begin
          o_int_r <= 1'b0;
        end else begin
          o_bord_r <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r      <= in_px.pixel;
      a_col_r      <= col_cnt_r;
      a_row_r      <= row_cnt_r;
      a_border_r   <= border;
      a_interior_r <= interior;
      a_fend_r     <= frame_end;
    end
    if (a_move) begin
      b_gx_r       <= gx_nxt;
      b_gy_r       <= gy_nxt;
      b_col_r      <= a_col_r;
      b_row_r      <= a_row_r;
      b_border_r   <= a_border_r;
      b_interior_r <= a_interior_r;
      b_fend_r     <= a_fend_r;
    end
    if (b_move) begin
      o_col_r  <= b_col_r;
      o_row_r  <= b_row_r;
      o_edge_r <= edge_nxt;
      o_fend_r <= b_fend_r;
    end
  end

  // interior result first, then border result
  assign out_res.valid         = o_int_r || o_bord_r;
  assign out_res.column        = o_int_r ? COLUMN_W'(o_col_r - XW'(1)) : COLUMN_W'(o_col_r);
  assign out_res.row           = o_int_r ? (o_row_r - ROW_W'(1)) : o_row_r;
  assign out_res.is_edge       = o_int_r && o_edge_r;
  assign out_res.last_of_item  = o_int_r ? !o_bord_r : 1'b1;
  assign out_res.last_of_frame = !o_int_r && o_fend_r;

endmodule

// ----- bench/tb_top.sv -----
// Testbench for sobel_edge_threshold: raster pixel frames in, edge decisions out.
// Uses set_pkg and the set_pixel_if, set_result_if and set_cfg_if interfaces of the RTL.
// A behavioral edge marker in this file predicts each result; random idling on both sides.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import set_pkg::*;

  localparam int          MAX_W         = 4096;
  localparam int          CENTRE_WEIGHT = 4;
  localparam int          RANDOM_ITEMS  = 420;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam cfg_idx_t    REG_UNUSED    = 2'd3;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic                is_edge;
    logic                last_of_item;
    logic                last_of_frame;
  } edge_res_t;

  typedef enum bit {ROW_PIXEL, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    cfg_idx_t  index;
    cfg_data_t data;
    pixel_t    pixel;
    bit        typed;
    edge_res_t want;
  } dir_row_t;

  localparam edge_res_t NO_RES   = '0;
  localparam int        DIR_ROWS = 28;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'hFF, 1'b1, '{12'd0, 16'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h00, 1'b1, '{12'd1, 16'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG,   REG_IMAGE_WIDTH,  23'd0,        8'h00, 1'b0, NO_RES},
    '{ROW_CFG,   REG_IMAGE_HEIGHT, 23'd0,        8'h00, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h80, 1'b1, '{12'd2, 16'd0, 1'b0, 1'b1, 1'b1}},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h7F, 1'b1, '{12'd0, 16'd0, 1'b0, 1'b1, 1'b1}},
    '{ROW_CFG,   REG_IMAGE_WIDTH,  23'd3,        8'h00, 1'b0, NO_RES},
    '{ROW_CFG,   REG_IMAGE_HEIGHT, 23'd3,        8'h00, 1'b0, NO_RES},
    '{ROW_CFG,   REG_THRESHOLD_SQ, 23'd0,        8'h00, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h10, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h20, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h30, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h40, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h50, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h60, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h70, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h80, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h90, 1'b0, NO_RES},
    '{ROW_CFG,   REG_THRESHOLD_SQ, 23'h7F_FFFF,  8'h00, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h00, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h00, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h00, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h80, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h80, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'h80, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'hFF, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'hFF, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  23'd0,        8'hFF, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;

  set_pixel_if  pix_ch();
  set_result_if res_ch();
  set_cfg_if    cfg_ch();

  sobel_edge_threshold dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (pix_ch),
    .out_res (res_ch),
    .cfg_wr  (cfg_ch)
  );

  // edge marker state
  logic [IMG_WIDTH_W-1:0]  img_width  = IMAGE_WIDTH_RST;
  logic [IMG_HEIGHT_W-1:0] img_height = IMAGE_HEIGHT_RST;
  logic [THRESH_W-1:0]     thresh_sq  = THRESHOLD_RST;
  pixel_t                  upper_line [MAX_W];
  pixel_t                  middle_line [MAX_W];
  pixel_t                  win [9];
  int unsigned             col_cnt;
  int unsigned             row_cnt;

  edge_res_t   pending_q[$];
  int unsigned mismatches;
  int unsigned pixels_in;
  int unsigned cycles = 0;
  bit          steady;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned eff_width();
    if (img_width == 0) return 1;
    if (img_width > MAX_W) return MAX_W;
    return img_width;
  endfunction

  function automatic int unsigned eff_height();
    return (img_height == 0) ? 1 : img_height;
  endfunction

  function automatic int wv(input int i);
    return int'(win[i]);
  endfunction

  function automatic logic window_edge();
    int     gx;
    int     gy;
    longint mag;
    gx  = (wv(6) + CENTRE_WEIGHT * wv(7) + wv(8)) - (wv(0) + CENTRE_WEIGHT * wv(1) + wv(2));
    gy  = (wv(2) + CENTRE_WEIGHT * wv(5) + wv(8)) - (wv(0) + CENTRE_WEIGHT * wv(3) + wv(6));
    mag = longint'(gx) * gx + longint'(gy) * gy;
    return (mag >= longint'(thresh_sq));
  endfunction

  function automatic void predict_pixel(input pixel_t p, ref edge_res_t outs[$]);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    pixel_t      top;
    pixel_t      mid;
    bit          row_end;
    bit          frame_end;
    bit          border;
    edge_res_t   r;
    w = eff_width();
    h = eff_height();
    x = col_cnt;
    y = row_cnt;
    top = upper_line[x];
    mid = middle_line[x];
    upper_line[x]  = mid;
    middle_line[x] = p;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = p;
    row_end   = (x + 1 >= w);
    frame_end = row_end && (y + 1 >= h);
    border    = (x == 0) || row_end || (y == 0) || (y + 1 >= h);
    outs.delete();
    if (x >= 2 && y >= 2) begin
      r.column        = COLUMN_W'(x - 1);
      r.row           = ROW_W'(y - 1);
      r.is_edge       = window_edge();
      r.last_of_item  = !border;
      r.last_of_frame = 1'b0;
      outs.push_back(r);
    end
    if (border) begin
      r.column        = COLUMN_W'(x);
      r.row           = ROW_W'(y);
      r.is_edge       = 1'b0;
      r.last_of_item  = 1'b1;
      r.last_of_frame = frame_end;
      outs.push_back(r);
    end
    if (row_end) begin
      col_cnt = 0;
      row_cnt = frame_end ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endfunction

  task automatic push_pixel(input pixel_t p, input bit typed, input edge_res_t want);
    int unsigned gap;
    edge_res_t   outs[$];
    gap = 0;
    while (!steady && $urandom_range(99) < 11) gap++;
    cfg_ch.valid <= 1'b0;
    if (gap != 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    predict_pixel(p, outs);
    if (typed) pending_q.push_back(want);
    else foreach (outs[k]) pending_q.push_back(outs[k]);
    pixels_in++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  img_width  = d[IMG_WIDTH_W-1:0];
      REG_IMAGE_HEIGHT: img_height = d[IMG_HEIGHT_W-1:0];
      REG_THRESHOLD_SQ: thresh_sq  = d[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  // quiet pixels give no result, so wait out the pipeline after the queue drains
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pixel_t next_pixel(input int unsigned mode);
    case (mode)
      0:       return pixel_t'($urandom_range(255));
      1:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return pixel_t'(col_cnt * 37 + row_cnt * 11 + $urandom_range(15));
    endcase
  endfunction

  task automatic feed_frame(input int unsigned mode);
    do push_pixel(next_pixel(mode), 1'b0, NO_RES);
    while (col_cnt != 0 || row_cnt != 0);
  endtask

  task automatic random_setup();
    cfg_data_t d;
    bit        mid_frame;
    mid_frame = (col_cnt != 0 || row_cnt != 0);
    // the width may only shrink inside a frame
    d = cfg_data_t'($urandom);
    d[IMG_WIDTH_W-1:0] = mid_frame ? IMG_WIDTH_W'($urandom_range(1, eff_width()))
                                   : IMG_WIDTH_W'($urandom_range(0, 12));
    write_reg(REG_IMAGE_WIDTH, d);
    d = cfg_data_t'($urandom);
    d[IMG_HEIGHT_W-1:0] = IMG_HEIGHT_W'($urandom_range(0, 9));
    write_reg(REG_IMAGE_HEIGHT, d);
    case ($urandom_range(5))
      0:       d = '0;
      1:       d = 23'd4681801;
      2:       d = 23'd4681800;
      default: d = cfg_data_t'($urandom_range(0, 900000));
    endcase
    write_reg(REG_THRESHOLD_SQ, d);
    if ($urandom_range(5) == 0) write_reg(REG_UNUSED, cfg_data_t'($urandom));
  endtask

  always @(posedge clk) res_ch.ready <= steady || ($urandom_range(99) >= 11);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[sobel_edge_threshold] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    edge_res_t exp_r;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: column %0d row %0d", res_ch.column, res_ch.row);
        mismatches++;
      end else begin
        exp_r = pending_q.pop_front();
        if (res_ch.column !== exp_r.column) begin
          $error("column: expected %0d, got %0d", exp_r.column, res_ch.column);
          mismatches++;
        end
        if (res_ch.row !== exp_r.row) begin
          $error("row: expected %0d, got %0d", exp_r.row, res_ch.row);
          mismatches++;
        end
        if (res_ch.is_edge !== exp_r.is_edge) begin
          $error("is_edge: expected %0b, got %0b", exp_r.is_edge, res_ch.is_edge);
          mismatches++;
        end
        if (res_ch.last_of_item !== exp_r.last_of_item) begin
          $error("last_of_item: expected %0b, got %0b", exp_r.last_of_item, res_ch.last_of_item);
          mismatches++;
        end
        if (res_ch.last_of_frame !== exp_r.last_of_frame) begin
          $error("last_of_frame: expected %0b, got %0b",
                 exp_r.last_of_frame, res_ch.last_of_frame);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned start_count;
    int unsigned n;
    int unsigned mode;
    mismatches = 0;
    pixels_in  = 0;
    steady     = 1'b0;
    col_cnt    = 0;
    row_cnt    = 0;
    foreach (upper_line[i]) upper_line[i] = '0;
    foreach (middle_line[i]) middle_line[i] = '0;
    foreach (win[i]) win[i] = '0;
    rst_n         <= 1'b0;
    pix_ch.valid  <= 1'b0;
    pix_ch.pixel  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_IMAGE_WIDTH;
    cfg_ch.data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind == ROW_PIXEL) settle();
        write_reg(dir_rows[i].index, dir_rows[i].data);
      end else begin
        push_pixel(dir_rows[i].pixel, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // width register above the line store depth, then shrunk mid-row to end the frame
    settle();
    write_reg(REG_IMAGE_WIDTH, 23'h7F_FFFF);
    write_reg(REG_IMAGE_HEIGHT, 23'd1);
    write_reg(REG_THRESHOLD_SQ, cfg_data_t'($urandom_range(0, 900000)));
    write_reg(REG_UNUSED, cfg_data_t'($urandom));
    repeat (40) push_pixel(next_pixel(0), 1'b0, NO_RES);
    settle();
    write_reg(REG_IMAGE_WIDTH, 23'd48);
    feed_frame(0);

    // tallest frame, cut short by lowering the height mid-frame
    settle();
    write_reg(REG_IMAGE_WIDTH, 23'd3);
    write_reg(REG_IMAGE_HEIGHT, 23'h7F_FFFF);
    repeat (15) push_pixel(next_pixel(2), 1'b0, NO_RES);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 23'd2);
    feed_frame(1);

    phase       = 0;
    start_count = pixels_in;
    while (pixels_in - start_count < RANDOM_ITEMS) begin
      settle();
      random_setup();
      steady = (phase >= 3 && phase <= 5);
      mode   = $urandom_range(2);
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, eff_width() * eff_height());
        repeat (n) push_pixel(next_pixel(mode), 1'b0, NO_RES);
      end else begin
        repeat ($urandom_range(1, 2)) feed_frame(mode);
      end
      phase++;
    end
    steady = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("[sobel_edge_threshold] OK");
    end else begin
      $display("[sobel_edge_threshold] ERROR");
    end
    $finish;
  end

endmodule
